// ===== hdl/spx_pkg.sv =====
// spx_pkg: shared types, constants and colour table for the scanline palette expander
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none

package spx_pkg;

    localparam int PIX_W        = 8;
    localparam int PIX_PER_WORD = 4;
    localparam int WORD_W       = PIX_W * PIX_PER_WORD;
    localparam int IN_DATA_W    = 24;
    localparam int DATA_PIX     = 12;
    localparam int BUF_PIX      = 16;
    localparam int PEND_PIX     = PIX_PER_WORD - 1;
    localparam int BORDER_4BPP  = 32;
    localparam int BORDER_1BPP  = 192;
    localparam int MAX_WORDS    = 50;
    localparam int CNT_W        = 6;
    localparam int NPIX_W       = 4;
    localparam int Q_DEPTH      = 4;
    localparam int Q_PTR_W      = 2;
    localparam int PAL_W        = 48;
    localparam int CFG_ADDR_W   = 1;

    localparam logic [CNT_W-1:0] BORDER_4BPP_WORDS = CNT_W'(BORDER_4BPP / PIX_PER_WORD);
    localparam logic [CNT_W-1:0] BORDER_1BPP_WORDS = CNT_W'(BORDER_1BPP / PIX_PER_WORD);
    localparam logic [CNT_W-1:0] MAX_WORDS_C       = CNT_W'(MAX_WORDS);

    // register indexes on the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_MODE    = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] REG_PALETTE = 1'b1;

    typedef logic [PIX_W-1:0] pix_t;

    typedef enum logic [1:0] {
        MODE_CONSOLE = 2'd0,
        MODE_4BPP_X3 = 2'd1,
        MODE_4BPP_X6 = 2'd2,
        MODE_1BPP    = 2'd3
    } mode_t;

    // one classified byte, handed from front end to back end
    typedef struct packed {
        pix_t [DATA_PIX-1:0] pix;          // expanded pixels, unused ones black
        logic [NPIX_W-1:0]   n_pix;        // number of expanded pixels
        logic [CNT_W-1:0]    border_words; // border width in words for this mode
        logic                first;
        logic                last;
    } cmd_t;

    // fixed physical colour table, 3-bit index to rgb332
    function automatic pix_t phys_rgb(input logic [2:0] idx);
        pix_t c;
        case (idx)
            3'd0:    c = 8'h00;
            3'd1:    c = 8'hE0;
            3'd2:    c = 8'h1C;
            3'd3:    c = 8'hFC;
            3'd4:    c = 8'h03;
            3'd5:    c = 8'hE3;
            3'd6:    c = 8'h1F;
            3'd7:    c = 8'hFF;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/spx_front.sv =====
// spx_front: configuration registers and byte classifier / pixel expander
// depends on spx_pkg; feeds commands into spx_queue
`timescale 1ns / 1ps
`default_nettype none

module spx_front (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_wr_en,
    input  wire logic [spx_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [spx_pkg::PAL_W-1:0]        cfg_wdata,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [spx_pkg::IN_DATA_W-1:0]    s_tdata,
    input  wire logic                             s_tuser,
    input  wire logic                             s_tlast,
    output logic                                  push,
    output spx_pkg::cmd_t                         push_cmd,
    input  wire logic                             push_ready
);
    import spx_pkg::*;

    mode_t              mode_reg;
    logic [PAL_W-1:0]   palette_reg;

    logic [7:0] src;
    pix_t       fg;
    pix_t       bg;
    pix_t       hi_c;
    pix_t       lo_c;
    pix_t       on_c;
    pix_t       off_c;

    // logical colour through the palette map and the physical table
    function automatic pix_t lookup(input logic [PAL_W-1:0] pal, input logic [3:0] n);
        logic [2:0] phys;
        phys = pal[3 * n +: 3];
        return phys_rgb(phys);
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_CONSOLE;
            palette_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_MODE:    mode_reg    <= mode_t'(cfg_wdata[1:0]);
                REG_PALETTE: palette_reg <= cfg_wdata;
                default:     ;
            endcase
        end
    end

    assign src   = s_tdata[7:0];
    assign fg    = s_tdata[15:8];
    assign bg    = s_tdata[23:16];
    assign hi_c  = lookup(palette_reg, src[7:4]);
    assign lo_c  = lookup(palette_reg, src[3:0]);
    assign on_c  = (mode_reg == MODE_CONSOLE) ? fg : lookup(palette_reg, 4'd1);
    assign off_c = (mode_reg == MODE_CONSOLE) ? bg : lookup(palette_reg, 4'd0);

    always_comb
    begin
        push_cmd       = '0;
        push_cmd.first = s_tuser;
        push_cmd.last  = s_tlast;
        case (mode_reg)
            MODE_CONSOLE, MODE_1BPP:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    push_cmd.pix[i] = src[7-i] ? on_c : off_c;
                end
                push_cmd.n_pix        = 4'd8;
                push_cmd.border_words = (mode_reg == MODE_1BPP) ? BORDER_1BPP_WORDS : '0;
            end
            MODE_4BPP_X3:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    push_cmd.pix[i]     = hi_c;
                    push_cmd.pix[i + 3] = lo_c;
                end
                push_cmd.n_pix        = 4'd6;
                push_cmd.border_words = BORDER_4BPP_WORDS;
            end
            MODE_4BPP_X6:
            begin
                for (int i = 0; i < 6; i++)
                begin
                    push_cmd.pix[i]     = hi_c;
                    push_cmd.pix[i + 6] = lo_c;
                end
                push_cmd.n_pix        = 4'd12;
                push_cmd.border_words = BORDER_4BPP_WORDS;
            end
            default: ;
        endcase
    end

    assign s_tready = push_ready;
    assign push     = s_tvalid && push_ready;

endmodule

`default_nettype wire

// ===== hdl/spx_queue.sv =====
// spx_queue: four-entry command queue between front end and back end
// depends on spx_pkg
`timescale 1ns / 1ps
`default_nettype none

module spx_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire spx_pkg::cmd_t push_cmd,
    output logic               push_ready,
    input  wire logic          pop,
    output logic               pop_valid,
    output spx_pkg::cmd_t      pop_cmd
);
    import spx_pkg::*;

    cmd_t                 mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_ptr_reg;
    logic [Q_PTR_W-1:0]   rd_ptr_reg;
    logic [Q_PTR_W:0]     count_reg;
    logic [Q_PTR_W-1:0]   wr_ptr_next;
    logic [Q_PTR_W-1:0]   rd_ptr_next;
    logic [Q_PTR_W:0]     count_next;

    assign push_ready = (count_reg != (Q_PTR_W+1)'(Q_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/spx_back.sv =====
// spx_back: pending-pixel merge, word sequencer and output register
// depends on spx_pkg; takes commands from spx_queue
`timescale 1ns / 1ps
`default_nettype none

module spx_back (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          pop_valid,
    input  wire spx_pkg::cmd_t                 pop_cmd,
    output logic                               pop,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [spx_pkg::WORD_W-1:0]         m_tdata,
    output logic                               m_tlast,
    output logic                               m_tuser
);
    import spx_pkg::*;

    // control
    logic                 act_reg, act_next;
    logic [CNT_W-1:0]     idx_reg, idx_next;
    logic [1:0]           pend_cnt_reg, pend_cnt_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    // payload
    pix_t [BUF_PIX-1:0]   buf_reg;
    pix_t [PEND_PIX-1:0]  pend_reg;
    logic [CNT_W-1:0]     total_reg;
    logic [CNT_W-1:0]     lw_reg;
    logic [CNT_W-1:0]     ldw_reg;
    logic                 rem_nz_reg;
    logic                 last_reg;
    logic [WORD_W-1:0]    m_tdata_reg;
    logic                 m_tlast_reg;
    logic                 m_tuser_reg;

    // load-side values
    logic [1:0]           p;
    logic [NPIX_W:0]      sum;
    logic [1:0]           d_words;
    logic [1:0]           rem;
    pix_t [BUF_PIX-1:0]   buf_next;
    logic [CNT_W-1:0]     l_words;
    logic [CNT_W-1:0]     r_words;
    logic [CNT_W:0]       total_raw;
    logic [CNT_W-1:0]     total_next;

    // emit-side values
    logic                 out_rdy;
    logic                 emit;
    logic                 at_end;
    logic                 done;
    logic [CNT_W-1:0]     sel_off;
    logic                 use_buf;
    logic [WORD_W-1:0]    word;

    always_comb
    begin
        p        = pop_cmd.first ? 2'd0 : pend_cnt_reg;
        sum      = (NPIX_W+1)'(p) + (NPIX_W+1)'(pop_cmd.n_pix);
        d_words  = sum[3:2];
        rem      = sum[1:0];
        // pending pixels first, then the new ones; everything past the run is black
        buf_next = (BUF_PIX*PIX_W)'(pop_cmd.pix) << (PIX_W * int'(p));
        for (int k = 0; k < PEND_PIX; k++)
        begin
            if (k < int'(p))
            begin
                buf_next[k] = pend_reg[k];
            end
        end
        l_words    = pop_cmd.first ? pop_cmd.border_words : '0;
        r_words    = pop_cmd.last ? pop_cmd.border_words + CNT_W'(rem != 2'd0) : '0;
        total_raw  = (CNT_W+1)'(l_words) + (CNT_W+1)'(d_words) + (CNT_W+1)'(r_words);
        total_next = (total_raw > (CNT_W+1)'(MAX_WORDS)) ? MAX_WORDS_C : total_raw[CNT_W-1:0];
    end

    assign out_rdy = !m_tvalid_reg || m_tready;
    assign emit    = act_reg && out_rdy;
    assign at_end  = (idx_reg == total_reg - CNT_W'(1));
    assign done    = emit && at_end;
    assign pop     = pop_valid && (!act_reg || done);

    assign sel_off = idx_reg - lw_reg;
    assign use_buf = (idx_reg >= lw_reg) &&
                     ((idx_reg < ldw_reg) || ((idx_reg == ldw_reg) && rem_nz_reg));
    assign word    = use_buf ? buf_reg[PIX_PER_WORD * sel_off[1:0] +: PIX_PER_WORD] : '0;

    always_comb
    begin
        act_next      = act_reg;
        idx_next      = idx_reg;
        pend_cnt_next = pend_cnt_reg;
        m_tvalid_next = m_tvalid_reg;
        if (emit)
        begin
            m_tvalid_next = 1'b1;
            idx_next      = idx_reg + CNT_W'(1);
            if (at_end)
            begin
                act_next = 1'b0;
            end
        end
        else if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end
        if (pop)
        begin
            act_next      = 1'b1;
            idx_next      = '0;
            pend_cnt_next = pop_cmd.last ? 2'd0 : rem;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg      <= 1'b0;
            idx_reg      <= '0;
            pend_cnt_reg <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            act_reg      <= act_next;
            idx_reg      <= idx_next;
            pend_cnt_reg <= pend_cnt_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            buf_reg    <= buf_next;
            pend_reg   <= buf_next[PIX_PER_WORD * d_words +: PEND_PIX];
            total_reg  <= total_next;
            lw_reg     <= l_words;
            ldw_reg    <= l_words + CNT_W'(d_words);
            rem_nz_reg <= (rem != 2'd0);
            last_reg   <= pop_cmd.last;
        end
        if (emit)
        begin
            m_tdata_reg <= word;
            m_tlast_reg <= at_end;
            m_tuser_reg <= at_end && last_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

`default_nettype wire

// ===== hdl/scanline_palette_expander_unit.sv =====
// scanline_palette_expander_unit: top level of the framebuffer byte to rgb332 word expander
// depends on spx_pkg, spx_front, spx_queue and spx_back
`timescale 1ns / 1ps
`default_nettype none

// Takes one framebuffer byte per input transfer and produces packed rgb332 words,
// four pixels per 32-bit word with the leftmost pixel in bits 7..0. The mode register
// picks console (8 pixels from per-byte fg/bg), 4bpp x3, 4bpp x6 or 1bpp expansion;
// palette_map maps sixteen logical colours onto the fixed eight-entry physical table.
// A byte flagged as line start first emits the black left border (and drops any
// pixels still pending); a byte flagged as line end emits the right border after its
// pixels and pads the last word with black. Borders are 8 words in the 4bpp modes,
// 48 words in 1bpp and none in console mode; a run is capped at 50 words.
// Throughput: the back end sends exactly one word per clock while words are owed and
// the output is not stalled; a byte produces 1 to 3 words when plain and up to 50
// with borders; the front end takes one byte per clock while the four-entry
// command queue has room, so it keeps accepting while borders drain.
// With the block idle a byte goes through the queue, the back-end load registers and the output register.
// Configuration may only be written while no byte is in flight. No clearing pass
// after reset.

module scanline_palette_expander_unit (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // configuration write port
    input  wire logic                             cfg_wr_en,
    input  wire logic [spx_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [spx_pkg::PAL_W-1:0]        cfg_wdata,
    // input stream
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    input  wire logic [spx_pkg::IN_DATA_W-1:0]    s_tdata,   // src_byte, fg_color, bg_color
    input  wire logic                             s_tuser,   // first_in_line
    input  wire logic                             s_tlast,   // last_in_line
    // output stream
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    output logic [spx_pkg::WORD_W-1:0]            m_tdata,   // pixel_word
    output logic                                  m_tlast,   // end_of_run
    output logic                                  m_tuser    // end_of_line
);
    import spx_pkg::*;

    // front end to queue
    logic push;
    logic push_ready;
    cmd_t push_cmd;
    // queue to back end
    logic pop;
    logic pop_valid;
    cmd_t pop_cmd;

    // classify each accepted transfer and expand its pixels
    spx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    // decouples byte intake from word output, lets borders drain without stalling input while it has room
    spx_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop        (pop),
        .pop_valid  (pop_valid),
        .pop_cmd    (pop_cmd)
    );

    // merges pending pixels, sequences border / data / padding words, output register
    spx_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// ===== hdl/spx_checker.sv =====
// spx_checker: port-level assertions for the scanline palette expander
// depends on spx_pkg; bound to scanline_palette_expander_unit at the end of this file
`timescale 1ns / 1ps
`default_nettype none

module spx_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         m_tvalid,
    input  wire logic                         m_tready,
    input  wire logic [spx_pkg::WORD_W-1:0]   m_tdata,
    input  wire logic                         m_tlast,
    input  wire logic                         m_tuser
);
    import spx_pkg::*;

    // a stalled output word holds with its flags
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) &&
                                   $stable(m_tlast) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // valid only drops after a transfer
    a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("output valid withdrawn without transfer");

    // end of line only ever sits on the last word of a run
    a_eol_on_eor: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("end of line without end of run");

    // nothing is offered straight out of reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rst_n) |-> !m_tvalid)
        else $error("output valid straight after reset");

endmodule

bind scanline_palette_expander_unit spx_checker u_spx_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
